[rtl/core/pidl_pkg.sv]
// Shared types and codes for the positional insert/delete list.
package pidl_pkg;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic upd;
        req_t kind;
    } cell_ctl_t;

    localparam int DATA_W  = 32;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 5;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 40;

endpackage

[rtl/core/positional_insert_delete_list.sv]
// Positional insert/delete list built as a chain of shifting cells.
// Usage: one request per clock. A request is taken whenever the result register is empty or
// its result is taken in the same cycle; its result shows in the cycle after acceptance. Every
// cell loads, holds or takes its left or right neighbor in the same cycle, so an insert or a
// delete shifts at once whatever the position; a read or delete output is the OR of the cell
// taps selected by position. Refused requests leave the list untouched and return zero.
module positional_insert_delete_list #(
    parameter int CAPACITY = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [1:0] req_type, [6:2] position, [38:7] value, [39] zero
    input  logic [pidl_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] read_value, [36:32] count, [38:37] status, [39] zero
    output logic [pidl_pkg::OUT_W-1:0]     m_axis_tdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > pidl_pkg::POS_W) ? CW : pidl_pkg::POS_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic [CW-1:0]                   count_reg;
    logic [CW-1:0]                   count_next;
    logic                            m_valid_reg;
    logic                            m_valid_next;
    logic [pidl_pkg::OUT_W-1:0]      m_data_reg;
    logic [pidl_pkg::OUT_W-1:0]      m_data_next;

    logic                            accept;
    pidl_pkg::req_t                  kind;
    logic [PW-1:0]                   pos_ext;
    logic [PW-1:0]                   cnt_ext;
    logic [pidl_pkg::DATA_W-1:0]     value;
    logic                            full;
    pidl_pkg::status_t               status;
    logic [pidl_pkg::DATA_W-1:0]     tap_or;
    logic [pidl_pkg::DATA_W-1:0]     read_value;
    pidl_pkg::cell_ctl_t             ctl;

    logic [pidl_pkg::DATA_W-1:0]     cell_q   [CAPACITY];
    logic [pidl_pkg::DATA_W-1:0]     cell_tap [CAPACITY];

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign kind    = pidl_pkg::req_t'(s_axis_tdata[1:0]);
    assign pos_ext = PW'(s_axis_tdata[6:2]);
    assign value   = s_axis_tdata[38:7];
    assign cnt_ext = PW'(count_reg);
    assign full    = (count_reg == CAP_CNT);

    always_comb
    begin
        status = pidl_pkg::ST_DONE;
        case (kind)
            pidl_pkg::REQ_APPEND:
            begin
                if (full)
                    status = pidl_pkg::ST_FULL;
            end
            pidl_pkg::REQ_INSERT:
            begin
                if (full)
                    status = pidl_pkg::ST_FULL;
                else if (pos_ext > cnt_ext)
                    status = pidl_pkg::ST_RANGE;
            end
            default:
            begin
                if (pos_ext >= cnt_ext)
                    status = pidl_pkg::ST_RANGE;
            end
        endcase
    end

    assign ctl.upd  = accept && (status == pidl_pkg::ST_DONE);
    assign ctl.kind = kind;

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [pidl_pkg::DATA_W-1:0] left_d;
            logic [pidl_pkg::DATA_W-1:0] right_d;

            if (i == 0)
            begin : g_first
                assign left_d = value;
            end
            else
            begin : g_mid_l
                assign left_d = cell_q[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_d = cell_q[i];
            end
            else
            begin : g_mid_r
                assign right_d = cell_q[i+1];
            end

            pidl_cell #(
                .IDX (i),
                .PW  (PW)
            ) u_cell (
                .clk   (clk),
                .ctl   (ctl),
                .pos   (pos_ext),
                .cnt   (cnt_ext),
                .value (value),
                .left  (left_d),
                .right (right_d),
                .q     (cell_q[i]),
                .tap   (cell_tap[i])
            );
        end
    endgenerate

    always_comb
    begin
        tap_or = '0;
        for (int i = 0; i < CAPACITY; i++)
            tap_or = tap_or | cell_tap[i];
    end

    always_comb
    begin
        read_value = '0;
        if ((status == pidl_pkg::ST_DONE) &&
            ((kind == pidl_pkg::REQ_DELETE) || (kind == pidl_pkg::REQ_READ)))
            read_value = tap_or;
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.upd)
        begin
            case (kind)
                pidl_pkg::REQ_APPEND: count_next = count_reg + CW'(1);
                pidl_pkg::REQ_INSERT: count_next = count_reg + CW'(1);
                pidl_pkg::REQ_DELETE: count_next = count_reg - CW'(1);
                default:              count_next = count_reg;
            endcase
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, status, pidl_pkg::COUNT_W'(count_next), read_value};
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

[rtl/core/pidl_cell.sv]
// One storage cell of the list chain: holds one entry and shifts with its neighbors.
module pidl_cell #(
    parameter int IDX = 0,
    parameter int PW  = 5
) (
    input  logic                          clk,
    input  pidl_pkg::cell_ctl_t           ctl,
    input  logic [PW-1:0]                 pos,
    input  logic [PW-1:0]                 cnt,
    input  logic [pidl_pkg::DATA_W-1:0]   value,
    input  logic [pidl_pkg::DATA_W-1:0]   left,
    input  logic [pidl_pkg::DATA_W-1:0]   right,
    output logic [pidl_pkg::DATA_W-1:0]   q,
    output logic [pidl_pkg::DATA_W-1:0]   tap
);

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [pidl_pkg::DATA_W-1:0] q_reg;
    logic [pidl_pkg::DATA_W-1:0] q_next;
    logic                        hit;
    logic                        above;
    logic                        tail;

    assign hit   = (MY_IDX == pos);
    assign above = (MY_IDX > pos);
    assign tail  = (MY_IDX == cnt);

    always_comb
    begin
        q_next = q_reg;
        if (ctl.upd)
        begin
            case (ctl.kind)
                pidl_pkg::REQ_APPEND:
                begin
                    if (tail)
                        q_next = value;
                end
                pidl_pkg::REQ_INSERT:
                begin
                    if (hit)
                        q_next = value;
                    else if (above)
                        q_next = left;
                end
                pidl_pkg::REQ_DELETE:
                begin
                    if (hit || above)
                        q_next = right;
                end
                default:
                begin
                    q_next = q_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q   = q_reg;
    assign tap = hit ? q_reg : '0;

endmodule

[rtl/core/pidl_checker.sv]
// Port-level assertions for the positional insert/delete list, bound to the top level.
module pidl_checker #(
    parameter int CAPACITY = 16
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [pidl_pkg::OUT_W-1:0]  m_axis_tdata
);

    localparam logic [pidl_pkg::COUNT_W-1:0] CAP_CNT = pidl_pkg::COUNT_W'(CAPACITY);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // every accepted request yields a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted request gave no result");

    // a full refusal reports a full list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[38:37] == pidl_pkg::ST_FULL)
        |-> (m_axis_tdata[36:32] == CAP_CNT))
        else $error("full status with count below capacity");

    // refused requests return zero
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[38:37] != pidl_pkg::ST_DONE)
        |-> (m_axis_tdata[31:0] == '0))
        else $error("refused request returned data");

endmodule

bind positional_insert_delete_list pidl_checker #(
    .CAPACITY (CAPACITY)
) u_pidl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/positional_insert_delete_list_tb.sv]
// Testbench for the positional insert/delete list: random stream traffic checked by a scoreboard.
`timescale 1ns / 1ps

module positional_insert_delete_list_tb;

    localparam int CAPACITY = 16;
    localparam int ITEMS = 1500;
    localparam int LIMIT = 400000;

    typedef struct {
        logic [31:0]         read_value;
        logic [4:0]          count;
        pidl_pkg::status_t   status;
    } list_result_t;

    class list_scoreboard;
        logic [31:0] slots [CAPACITY];
        int fill;
        int errors;
        list_result_t pending_results[$];

        function new();
            fill = 0;
            errors = 0;
        endfunction

        function int level();
            return fill;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        function list_result_t list_update(pidl_pkg::req_t kind, logic [4:0] pos,
                                           logic [31:0] val);
            list_result_t r;
            int i;
            r.read_value = '0;
            r.status = pidl_pkg::ST_DONE;
            case (kind)
                pidl_pkg::REQ_APPEND:
                    if (fill >= CAPACITY)
                        r.status = pidl_pkg::ST_FULL;
                    else
                    begin
                        slots[fill] = val;
                        fill++;
                    end
                pidl_pkg::REQ_INSERT:
                    if (fill >= CAPACITY)
                        r.status = pidl_pkg::ST_FULL;
                    else if (int'(pos) > fill)
                        r.status = pidl_pkg::ST_RANGE;
                    else
                    begin
                        for (i = fill; i > int'(pos); i--)
                            slots[i] = slots[i - 1];
                        slots[pos] = val;
                        fill++;
                    end
                pidl_pkg::REQ_DELETE:
                    if (int'(pos) >= fill)
                        r.status = pidl_pkg::ST_RANGE;
                    else
                    begin
                        r.read_value = slots[pos];
                        for (i = int'(pos); i + 1 < fill; i++)
                            slots[i] = slots[i + 1];
                        fill--;
                    end
                default:
                    if (int'(pos) >= fill)
                        r.status = pidl_pkg::ST_RANGE;
                    else
                        r.read_value = slots[pos];
            endcase
            r.count = fill[4:0];
            return r;
        endfunction

        function void note_request(pidl_pkg::req_t kind, logic [4:0] pos, logic [31:0] val);
            pending_results.push_back(list_update(kind, pos, val));
        endfunction

        task check_result(logic [pidl_pkg::OUT_W-1:0] data);
            list_result_t exp_r;
            logic [31:0] got_value;
            logic [4:0] got_count;
            logic [1:0] got_status;
            got_value = data[31:0];
            got_count = data[36:32];
            got_status = data[38:37];
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected result %h", data));
                return;
            end
            exp_r = pending_results.pop_front();
            if (got_value !== exp_r.read_value)
                report($sformatf("read_value got %h exp %h", got_value, exp_r.read_value));
            if (got_count !== exp_r.count)
                report($sformatf("count got %0d exp %0d", got_count, exp_r.count));
            if (got_status !== exp_r.status)
                report($sformatf("status got %0d exp %0d", got_status, exp_r.status));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // [1:0] req_type, [6:2] position, [38:7] value, [39] zero
    logic [pidl_pkg::IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // [31:0] read_value, [36:32] count, [38:37] status, [39] zero
    logic [pidl_pkg::OUT_W-1:0] m_axis_tdata;

    list_scoreboard sb = new();
    int src_gap_max = 4;
    int rx_gap_max = 4;
    int rx_hold = 0;
    int cycles = 0;

    positional_insert_delete_list #(.CAPACITY(CAPACITY)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task send_request(pidl_pkg::req_t kind, logic [4:0] pos, logic [31:0] val);
        int gap;
        gap = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, val, pos, kind};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(kind, pos, val);
    endtask

    function logic [31:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task random_request(bit filling);
        int r;
        int lvl;
        pidl_pkg::req_t kind;
        logic [4:0] pos;
        r = $urandom_range(0, 99);
        lvl = sb.level();
        if (filling)
            kind = (r < 35) ? pidl_pkg::REQ_APPEND :
                   (r < 65) ? pidl_pkg::REQ_INSERT :
                   (r < 80) ? pidl_pkg::REQ_READ : pidl_pkg::REQ_DELETE;
        else
            kind = (r < 10) ? pidl_pkg::REQ_APPEND :
                   (r < 25) ? pidl_pkg::REQ_INSERT :
                   (r < 45) ? pidl_pkg::REQ_READ : pidl_pkg::REQ_DELETE;
        if ($urandom_range(0, 99) < 15)
            pos = 5'($urandom_range(0, 31));
        else if (kind == pidl_pkg::REQ_INSERT)
            pos = 5'($urandom_range(0, lvl));
        else
            pos = (lvl > 0) ? 5'($urandom_range(0, lvl - 1)) : 5'd0;
        send_request(kind, pos, pick_value());
    endtask

    // receive side: random stalls plus a single long hold-off
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            if (rx_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            gap = (rx_gap_max == 0) ? 0 : $urandom_range(0, rx_gap_max);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata);
        end
    end

    initial
    begin
        bit filling;
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, range checks and shifting at both ends
        send_request(pidl_pkg::REQ_READ, 5'd0, 32'h0);
        send_request(pidl_pkg::REQ_DELETE, 5'd0, 32'h0);
        send_request(pidl_pkg::REQ_INSERT, 5'd1, 32'h1);
        send_request(pidl_pkg::REQ_INSERT, 5'd0, 32'h7fff_ffff);
        send_request(pidl_pkg::REQ_APPEND, 5'd31, 32'h8000_0000);
        send_request(pidl_pkg::REQ_INSERT, 5'd1, 32'hffff_ffff);
        send_request(pidl_pkg::REQ_INSERT, 5'd3, 32'h0);
        send_request(pidl_pkg::REQ_READ, 5'd31, 32'hffff_ffff);
        send_request(pidl_pkg::REQ_READ, 5'd2, 32'h0);
        send_request(pidl_pkg::REQ_DELETE, 5'd0, 32'h0);
        send_request(pidl_pkg::REQ_DELETE, 5'd2, 32'h0);
        while (sb.level() < CAPACITY)
            send_request(pidl_pkg::REQ_APPEND, 5'd0, pick_value());
        send_request(pidl_pkg::REQ_APPEND, 5'd0, 32'h5a5a_5a5a);
        // full wins over a bad position
        send_request(pidl_pkg::REQ_INSERT, 5'd31, 32'h1234_5678);
        send_request(pidl_pkg::REQ_READ, 5'd15, 32'h0);
        send_request(pidl_pkg::REQ_READ, 5'd16, 32'h0);
        send_request(pidl_pkg::REQ_DELETE, 5'd15, 32'h0);

        filling = 1'b0;
        for (n = 0; n < ITEMS; n++)
        begin
            if (n % 150 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: src_gap_max = 0;
                    1: src_gap_max = 16;
                    default: src_gap_max = 3;
                endcase
                case ($urandom_range(0, 2))
                    0: rx_gap_max = 0;
                    1: rx_gap_max = 16;
                    default: rx_gap_max = 3;
                endcase
            end
            if (n == 500)
            begin
                src_gap_max = 0;
                rx_hold = 300;
            end
            if (n == 1000)
            begin
                s_axis_tvalid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            if (sb.level() >= CAPACITY)
                filling = 1'b0;
            else if (sb.level() == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 99) < 3)
                filling = ~filling;
            random_request(filling);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
